// ===== design/plt_pkg.sv =====
package plt_pkg;

  localparam int unsigned MaxPeersDefault = 64;
  localparam logic [15:0] TimeoutReset = 16'd10;

  typedef enum logic [1:0] {
    REQ_ALIVE  = 2'd0,
    REQ_GET    = 2'd1,
    REQ_SWEEP  = 2'd2,
    REQ_FORGET = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_GIVEN     = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_SWEPT     = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    CFG_TIMEOUT = 1'd0,
    CFG_RANDOM  = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_ARD,
    S_ACHK,
    S_GRD,
    S_GOUT,
    S_SRD,
    S_SCHK,
    S_SLRD,
    S_SMOVE,
    S_OUT
  } state_e;

  // Entry as stored: address, port, last-seen time
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;

endpackage

// ===== design/peer_liveness_table.sv =====
// Peer liveness table: up to MaxPeers peers (address, port, last-seen) in one
// RAM with a registered read, plus a live count. Items are handled one at a
// time, and the input is held off while a result waits in the output register,
// so the next item is taken the cycle after the result transfer. An alive item
// reads and compares the stored entries in turn until it finds the peer or
// reaches the count. A get-node item in random mode first takes the remainder
// of the random value by the count (16-step remainder); on an empty table it
// answers without a read. A sweep checks each entry in turn and moves the last
// entry into the place of each evicted one. Forget answers at the accepting
// edge. No clearing pass after reset is needed.
module peer_liveness_table import plt_pkg::*; #(
  parameter int unsigned MaxPeers = MaxPeersDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0], peer_addr[33:2], peer_port[49:34], now_seconds[81:50],
  // random_value[97:82], zero fill to 104
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], node_addr[34:3], node_port[50:35], peer_total[57:51],
  // evicted_total[64:58], zero fill to 72
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int unsigned AW = (MaxPeers > 1) ? $clog2(MaxPeers) : 1;
  localparam int unsigned CW = $clog2(MaxPeers + 1);
  localparam logic [CW-1:0] Full = CW'(MaxPeers);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, gone_q, gone_d;
  logic [31:0] a_q, a_d, now_q, now_d;
  logic [15:0] p_q, p_d, rnd_q, rnd_d;
  logic [15:0] tmo_q;
  logic        rmode_q;

  logic        ovld_q, ovld_d;
  logic [71:0] odata_q, odata_d;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  logic        mstart, mdone;
  logic [CW-1:0] mrem;

  plt_ram #(.Width($bits(entry_t)), .Depth(MaxPeers)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  plt_mod #(.CntW(CW)) u_mod (
    .clk_i, .rst_ni, .start_i(mstart), .dividend_i(rnd_q),
    .divisor_i(cnt_q), .done_o(mdone), .rem_o(mrem)
  );

  function automatic logic [71:0] pack_out(status_e s, logic [31:0] na,
                                           logic [15:0] np, logic [6:0] pt,
                                           logic [6:0] ev);
    return {7'd0, ev, pt, np, na, s};
  endfunction

  logic [31:0] age;
  logic [6:0]  cnt7, gone7;
  assign age   = now_q - rdata.seen;
  assign cnt7  = 7'(cnt_q);
  assign gone7 = 7'(gone_q);

  assign s_axis_tready = (state_q == S_IDLE) && !ovld_q;

  // Item sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; idx_d = idx_q; gone_d = gone_q;
    a_d = a_q; p_d = p_q; now_d = now_q; rnd_d = rnd_q;
    ovld_d = ovld_q; odata_d = odata_q;
    we = 1'b0; waddr = idx_q[AW-1:0]; wdata = '{addr: a_q, port: p_q, seen: now_q};
    raddr = idx_q[AW-1:0];
    mstart = 1'b0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          a_d   = s_axis_tdata[33:2];
          p_d   = s_axis_tdata[49:34];
          now_d = s_axis_tdata[81:50];
          rnd_d = s_axis_tdata[97:82];
          idx_d = '0; gone_d = '0;
          unique case (req_e'(s_axis_tdata[1:0]))
            REQ_ALIVE:  state_d = S_ARD;
            REQ_GET:    state_d = S_MOD;
            REQ_SWEEP:  state_d = S_SRD;
            REQ_FORGET: begin
              cnt_d = '0;
              ovld_d = 1'b1;
              odata_d = pack_out(ST_CLEARED, '0, '0, '0, '0);
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        if (cnt_q == '0) begin
          ovld_d = 1'b1;
          odata_d = pack_out(ST_EMPTY, '0, '0, cnt7, '0);
          state_d = S_IDLE;
        end else if (!rmode_q) begin
          idx_d = '0; state_d = S_GRD;
        end else begin
          mstart = 1'b1; state_d = S_GOUT;
        end
      end
      S_GOUT: begin
        if (mdone) begin
          idx_d = mrem; state_d = S_GRD;
        end
      end
      S_GRD: state_d = S_OUT;
      S_OUT: begin
        ovld_d = 1'b1;
        odata_d = pack_out(ST_GIVEN, rdata.addr, rdata.port, cnt7, '0);
        state_d = S_IDLE;
      end
      // Alive: issue read of idx, then compare
      S_ARD: begin
        if (idx_q >= cnt_q) begin
          ovld_d = 1'b1;
          state_d = S_IDLE;
          if (cnt_q >= Full) begin
            odata_d = pack_out(ST_FULL, '0, '0, cnt7, '0);
          end else begin
            we = 1'b1; waddr = cnt_q[AW-1:0];
            cnt_d = cnt_q + 1'b1;
            odata_d = pack_out(ST_ADDED, '0, '0, 7'(cnt_q + 1'b1), '0);
          end
        end else begin
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        if (rdata.addr == a_q && rdata.port == p_q) begin
          we = 1'b1;
          ovld_d = 1'b1;
          odata_d = pack_out(ST_REFRESHED, '0, '0, cnt7, '0);
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_ARD;
        end
      end
      // Sweep
      S_SRD: begin
        if (idx_q >= cnt_q) begin
          ovld_d = 1'b1;
          odata_d = pack_out(ST_SWEPT, '0, '0, cnt7, gone7);
          state_d = S_IDLE;
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (age > {16'd0, tmo_q}) begin
          cnt_d = cnt_q - 1'b1;
          gone_d = gone_q + 1'b1;
          raddr = cnt_d[AW-1:0];
          state_d = S_SLRD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end
      // Keep the last entry on the read port until it is moved
      S_SLRD: begin
        raddr = cnt_q[AW-1:0];
        state_d = S_SMOVE;
      end
      S_SMOVE: begin
        we = 1'b1; wdata = rdata;
        state_d = S_SRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      tmo_q   <= TimeoutReset;
      rmode_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TIMEOUT: tmo_q <= cfg_wdata_i;
          CFG_RANDOM:  rmode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; gone_q <= gone_d;
    a_q <= a_d; p_q <= p_d; now_q <= now_d; rnd_q <= rnd_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  // The count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("peer count overflow");
  // No item is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> !s_axis_tready) else $error("accept with pending result");
  // A sweep only checks entries below the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCHK) |-> (idx_q < cnt_q)) else $error("sweep index past count");

endmodule

// ===== design/plt_ram.sv =====
module plt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/plt_mod.sv =====
// Restoring remainder of a 16-bit value by a count, one bit per cycle.
module plt_mod import plt_pkg::*; #(
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [15:0]     dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [CntW-1:0] rem_o
);

  logic [15:0]   num_q, num_d;
  logic [CntW:0] rem_q, rem_d;
  logic [CntW:0] trial;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [CntW-1:0] div_q, div_d;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    div_d  = div_q;
    trial  = {rem_q[CntW-1:0], num_q[15]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[14:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
      end
    end
  end

  assign rem_o = rem_q[CntW-1:0];

  // done pulses the cycle after the last step
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      fin_q  <= busy_q && !start_i && (cnt_q == 5'd15);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = fin_q;

endmodule
